// ===== rtl/cid_pkg.sv =====
// Shared types and constants for the caller-ID frame to USB packet converter.
// Used by the front parser, the burst queue, the burst sequencer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cid_pkg;

  localparam int STORE_DEPTH   = 11;
  localparam int STORE_IDX_W   = $clog2(STORE_DEPTH);
  localparam int BURST_LEN     = 20;
  localparam int PKT_SPLIT     = 10;
  localparam int POS_W         = $clog2(BURST_LEN);
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] SYNC_RESET = 8'h80;
  localparam logic [7:0] TYPE_RESET = 8'h02;
  localparam logic [7:0] CMD_RESET  = 8'd42;
  localparam logic [7:0] PKT_LEN    = 8'd8;
  localparam logic [7:0] MARK_BYTE  = 8'hAA;
  localparam logic [7:0] TAG_BYTE   = 8'h01;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SYNC = 2'd0,
    REG_TYPE = 2'd1,
    REG_CMD  = 2'd2
  } reg_idx_t;

  // Snapshot of the digit store handed from front to back
  typedef logic [STORE_DEPTH-1:0][7:0] store_t;

  // Front to queue push request
  typedef struct packed {
    logic   push;
    store_t snap;
  } push_req_t;

endpackage

`default_nettype wire

// ===== rtl/cid_front.sv =====
// Frame parser: sync/type/length detection, countdown and the 11-byte digit store.
// Depends on cid_pkg; pushes a store snapshot when a frame's countdown ends.
`timescale 1ns / 1ps
`default_nettype none

module cid_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [7:0]         sync_byte,
  input  wire logic [7:0]         type_byte,
  output cid_pkg::push_req_t      req
);
  import cid_pkg::*;

  typedef enum logic [3:0] {
    WAIT_SYNC = 4'b0001,
    WAIT_TYPE = 4'b0010,
    WAIT_LEN  = 4'b0100,
    DATA      = 4'b1000
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] remaining, remaining_next;
  store_t     store, store_next;
  logic [7:0] rem_m1;
  logic       push;

  assign rem_m1 = remaining - 8'd1;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    store_next     = store;
    push           = 1'b0;
    if (accept) begin
      if (rx_byte == sync_byte) begin
        phase_next = WAIT_TYPE;
      end else begin
        unique case (phase)
          WAIT_SYNC: ;
          WAIT_TYPE: begin
            if (rx_byte == type_byte) phase_next = WAIT_LEN;
          end
          WAIT_LEN: begin
            remaining_next = rx_byte;
            phase_next     = DATA;
          end
          DATA: begin
            // indices above the store are dropped
            if (remaining != 8'd0 && remaining <= 8'(STORE_DEPTH))
              store_next[rem_m1[STORE_IDX_W-1:0]] = rx_byte;
            remaining_next = rem_m1;
            if (rem_m1 == 8'd0) begin
              phase_next = WAIT_SYNC;
              push       = 1'b1;
            end
          end
          default: phase_next = WAIT_SYNC;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= WAIT_SYNC;
      remaining <= 8'd0;
      store     <= '0;
    end else begin
      phase     <= phase_next;
      remaining <= remaining_next;
      store     <= store_next;
    end
  end

  assign req.push = push;
  assign req.snap = store_next;

endmodule

`default_nettype wire

// ===== rtl/cid_queue.sv =====
// Short queue of store snapshots between the frame parser and the burst sequencer.
// Depends on cid_pkg for the snapshot type.
`timescale 1ns / 1ps
`default_nettype none

module cid_queue #(
  parameter int DEPTH = cid_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cid_pkg::push_req_t req,
  input  wire logic               pop,
  output logic                    full,
  output logic                    not_empty,
  output cid_pkg::store_t         head
);
  import cid_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  store_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign do_push   = req.push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= req.snap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cid_back.sv =====
// Burst sequencer: walks the twenty-byte two-packet burst into an output register.
// Depends on cid_pkg; takes one snapshot from the queue per burst.
`timescale 1ns / 1ps
`default_nettype none

module cid_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire cid_pkg::store_t    q_head,
  output logic                    q_pop,
  input  wire logic [7:0]         usb_write_cmd,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    is_command,
  output logic [7:0]              out_byte,
  output logic                    last_of_run
);
  import cid_pkg::*;

  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(BURST_LEN - 1);
  localparam logic [POS_W-1:0] POS_SPLIT = POS_W'(PKT_SPLIT);
  // first data byte of each packet sits after cmd, len, mark, tag
  localparam logic [POS_W-1:0] POS_HDR   = POS_W'(4);
  // store index = base - position within the burst
  localparam logic [POS_W-1:0] BASE_A    = POS_W'(STORE_DEPTH + 3);
  localparam logic [POS_W-1:0] BASE_B    = POS_W'(BURST_LEN - 2);

  store_t           burst;
  logic             active;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] rel;
  logic [POS_W-1:0] sidx;
  logic             sel_cmd;
  logic [7:0]       sel_byte;
  logic             advance;

  assign advance = !out_valid || !out_stall;
  assign q_pop   = !active && q_valid;

  always_comb begin
    rel      = (pos >= POS_SPLIT) ? pos - POS_SPLIT : pos;
    sidx     = (pos >= POS_SPLIT) ? BASE_B - pos : BASE_A - pos;
    sel_cmd  = 1'b0;
    sel_byte = 8'd0;
    priority if (pos == POS_LAST) begin
      sel_byte = MARK_BYTE;
    end else if (rel == POS_W'(0)) begin
      sel_cmd  = 1'b1;
      sel_byte = usb_write_cmd;
    end else if (rel == POS_W'(1)) begin
      sel_byte = PKT_LEN;
    end else if (rel == POS_W'(2)) begin
      sel_byte = MARK_BYTE;
    end else if (rel == POS_W'(3)) begin
      sel_byte = TAG_BYTE;
    end else if (rel >= POS_HDR) begin
      sel_byte = burst[sidx[STORE_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) burst <= q_head;
    if (advance && active) begin
      is_command  <= sel_cmd;
      out_byte    <= sel_byte;
      last_of_run <= (pos == POS_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
        pos    <= '0;
      end else if (advance && active) begin
        pos <= pos + POS_W'(1);
        if (pos == POS_LAST) active <= 1'b0;
      end
      if (advance) out_valid <= active;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/caller_id_frame_to_usb_packets_top.sv =====
// Top level of the caller-ID frame to USB packet converter.
// Depends on cid_pkg, cid_front, cid_queue and cid_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  input    | in_valid / in_stall    | rx_byte
//  output   | out_valid / out_stall  | is_command, out_byte, last_of_run
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// The parser never waits on the burst to accept a received byte unless the
// snapshot queue is full. A completed frame produces twenty bytes, one per
// cycle while out_stall is low, from the sequencer's output register, after the
// snapshot is pulled from the queue. Reset is synchronous and clears the phase,
// countdown, digit store, queue and output valid. Output stall holds the byte.
`timescale 1ns / 1ps
`default_nettype none

module caller_id_frame_to_usb_packets_top #(
  parameter int QDEPTH = cid_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            is_command,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import cid_pkg::*;

  logic       [7:0] sync_byte, type_byte, usb_write_cmd;
  push_req_t        req;
  store_t           q_head;
  logic             q_full, q_valid, q_pop;
  logic             in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte     <= SYNC_RESET;
      type_byte     <= TYPE_RESET;
      usb_write_cmd <= CMD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SYNC: sync_byte     <= cfg_data;
        REG_TYPE: type_byte     <= cfg_data;
        REG_CMD:  usb_write_cmd <= cfg_data;
        default:  ;
      endcase
    end
  end

  cid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .rx_byte   (rx_byte),
    .sync_byte (sync_byte),
    .type_byte (type_byte),
    .req       (req)
  );

  cid_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  cid_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .usb_write_cmd (usb_write_cmd),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_command    (is_command),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run)
  );

endmodule

`default_nettype wire

// ===== rtl/cid_checker.sv =====
// Port-level checks for the caller-ID to USB packet converter.
// Bound to caller_id_frame_to_usb_packets_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module cid_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       is_command,
  input wire logic [7:0] out_byte,
  input wire logic       last_of_run
);

  // the output register is empty right after reset
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_command))
    else $error("stalled word changed");

  // a command word is always followed by the packet length, never another command
  a_cmd_then_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && is_command |=> !(out_valid && is_command))
    else $error("two command words in a row");

  a_last_is_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> !is_command && out_byte == 8'hAA)
    else $error("final word of burst is not the trailing mark");

endmodule

bind caller_id_frame_to_usb_packets_top cid_checker u_cid_checker (.*);

`default_nettype wire

// ===== tb/caller_id_frame_to_usb_packets_top_tb.sv =====
// Self-checking testbench for the caller-ID frame to USB packet converter.
// Needs cid_pkg and caller_id_frame_to_usb_packets_top; a scoreboard class predicts each
// twenty-word burst from the received bytes and checks the output words in order.
`timescale 1ns / 1ps

module caller_id_frame_to_usb_packets_top_tb;
  import cid_pkg::*;

  typedef enum logic [1:0] {
    WAIT_SYNC,
    WAIT_TYPE,
    WAIT_LEN,
    TAKE_DATA
  } frame_phase_t;

  typedef struct packed {
    logic       is_cmd;
    logic [7:0] data;
    logic       last;
  } usb_word_t;

  class usb_burst_scoreboard;
    logic [7:0]   sync_val;
    logic [7:0]   type_val;
    logic [7:0]   cmd_val;
    frame_phase_t phase;
    logic [7:0]   countdown;
    logic [7:0]   digits [1:STORE_DEPTH];
    usb_word_t    pending [$];
    int           errors;
    int           bytes_in;
    int           bursts;
    int           words_ok;

    function new();
      sync_val = SYNC_RESET;
      type_val = TYPE_RESET;
      cmd_val = CMD_RESET;
      phase = WAIT_SYNC;
      countdown = '0;
      foreach (digits[i]) digits[i] = '0;
      errors = 0;
      bytes_in = 0;
      bursts = 0;
      words_ok = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [7:0] v);
      case (idx)
        REG_SYNC: sync_val = v;
        REG_TYPE: type_val = v;
        REG_CMD:  cmd_val = v;
        default: ;
      endcase
    endfunction

    function void note_rx(logic [7:0] b);
      logic [7:0] val;
      int pos;
      bytes_in++;
      // sync wins in every phase
      if (b == sync_val) begin
        phase = WAIT_TYPE;
        return;
      end
      case (phase)
        WAIT_TYPE: if (b == type_val) phase = WAIT_LEN;
        WAIT_LEN: begin
          countdown = b;
          phase = TAKE_DATA;
        end
        TAKE_DATA: begin
          // indices above the store are dropped; zero wraps to 255
          if (countdown != 0 && countdown <= STORE_DEPTH) digits[countdown] = b;
          countdown = countdown - 8'd1;
          if (countdown == 0) begin
            phase = WAIT_SYNC;
            bursts++;
            for (int k = 0; k < BURST_LEN; k++) begin
              pos = k % PKT_SPLIT;
              if (pos == 0) val = cmd_val;
              else if (pos == 1) val = PKT_LEN;
              else if (pos == 2) val = MARK_BYTE;
              else if (pos == 3) val = TAG_BYTE;
              else if (k < PKT_SPLIT) val = digits[15 - pos];          // digits 11..6
              else if (pos < PKT_SPLIT - 1) val = digits[9 - pos];     // digits 5..1
              else val = MARK_BYTE;
              pending.push_back('{pos == 0, val, k == BURST_LEN - 1});
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task check_out(logic c, logic [7:0] b, logic l);
      usb_word_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word cmd=%0b byte=%02h last=%0b", c, b, l));
        return;
      end
      w = pending.pop_front();
      if (c !== w.is_cmd) report($sformatf("is_command %0b, want %0b", c, w.is_cmd));
      if (b !== w.data) report($sformatf("out_byte %02h, want %02h", b, w.data));
      if (l !== w.last) report($sformatf("last_of_run %0b, want %0b", l, w.last));
      if (c === w.is_cmd && b === w.data && l === w.last) words_ok++;
    endtask
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = '0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = REG_SYNC;
  logic [7:0] cfg_data = '0;
  logic       in_stall;
  logic       out_valid;
  logic       is_command;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       cfg_ready;

  usb_burst_scoreboard sb = new();
  int tx_idle_pct = 30;
  int rx_idle_pct = 30;
  int hold_request = 0;

  caller_id_frame_to_usb_packets_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_command (is_command),
    .out_byte   (out_byte),
    .last_of_run(last_of_run),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(15) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == sb.sync_val) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic logic [7:0] pick_len();
    logic [7:0] n;
    do
      n = ($urandom_range(7) == 0) ? 8'($urandom_range(30, 12)) : 8'($urandom_range(11, 1));
    while (n == sb.sync_val);
    return n;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_rx(b);
  endtask

  task automatic send_frame(input logic [7:0] len, input int n_data);
    logic [7:0] junk;
    send_byte(sb.sync_val);
    // now and then a wrong type byte the parser must skip
    if ($urandom_range(7) == 0) begin
      do junk = 8'($urandom); while (junk == sb.sync_val || junk == sb.type_val);
      send_byte(junk);
    end
    send_byte(sb.type_val);
    send_byte(len);
    repeat (n_data) send_byte(data_byte());
  endtask

  // hold until every expected word is out, then let the parser settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] s, input logic [7:0] t, input logic [7:0] c);
    reg_idx_t   regs [3];
    logic [7:0] vals [3];
    regs = '{REG_SYNC, REG_TYPE, REG_CMD};
    vals = '{s, t, c};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n_items);
    int framed;
    int pick;
    logic [7:0] len;
    framed = 0;
    while (framed < n_items) begin
      pick = $urandom_range(99);
      len = pick_len();
      if (pick < 72) begin
        send_frame(len, len);
        framed += 3 + len;
      end else if (pick < 85) begin
        // truncated frame: the next sync restarts detection
        pick = $urandom_range(len - 1, 0);
        send_frame(len, pick);
        framed += 3 + pick;
      end else begin
        pick = $urandom_range(5, 1);
        repeat (pick) send_byte(8'($urandom));
        framed += pick;
      end
    end
  endtask

  // output side: check accepted words and drive stall
  initial begin
    int stall_left;
    int hold_left;
    int g;
    stall_left = 0;
    hold_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall) sb.check_out(is_command, out_byte, last_of_run);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        g = pick_gap(rx_idle_pct);
        out_stall <= (g > 0);
        stall_left = (g > 0) ? g - 1 : 0;
      end
    end
  end

  initial begin
    logic [7:0] directed [];
    logic [7:0] s;
    logic [7:0] t;
    directed = '{8'h00, 8'hFF,                            // idle bytes before any sync
                 8'h80, 8'h03, 8'h02, 8'h01, 8'hFF,       // wrong type, one-digit frame
                 8'h80, 8'h02, 8'h0B, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h7F, 8'h01,
                 8'hFE, 8'h33, 8'hCC, 8'h0F, 8'hF0,       // full eleven digits
                 8'h80, 8'h02, 8'h03, 8'h11,              // sync lands inside the data
                 8'h80, 8'h02, 8'h02, 8'h22, 8'h44};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i]);
    send_frame(8'd0, 256);          // zero length wraps to 255
    send_frame(8'd14, 14);          // top indices dropped
    drain();

    // receiver backs off while short frames keep coming, so the input stalls
    tx_idle_pct = 0;
    hold_request = 400;
    repeat (6) send_frame(8'd1, 1);
    drain();

    set_config(8'h00, 8'hFF, 8'hFF);
    tx_idle_pct = 50;
    rx_idle_pct = 50;
    random_phase(10);
    drain();

    set_config(8'hFF, 8'h00, 8'h00);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(10);
    drain();

    s = 8'($urandom);
    do t = 8'($urandom); while (t == s);
    set_config(s, t, 8'($urandom));
    tx_idle_pct = 70;
    rx_idle_pct = 20;
    random_phase(10);
    drain();

    set_config(SYNC_RESET, TYPE_RESET, CMD_RESET);
    tx_idle_pct = 20;
    rx_idle_pct = 70;
    random_phase(10);
    drain();

    $display("Run covered %0d received bytes and %0d bursts over five register settings,",
             sb.bytes_in, sb.bursts);
    $display("with %0d USB words matched and %0d errors.", sb.words_ok, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d words still expected", sb.pending.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
